// ===== hw/rtl/signed_integer_to_decimal_ascii_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef SIGNED_INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SIDA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sida assertion failed");

// Check a property on every clock edge, reset included.
`define SIDA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("sida assertion failed");

`endif

// ===== hw/rtl/sida_pkg.sv =====
package sida_pkg;

  localparam int VALUE_W        = 32;
  localparam int BIT_CNT_W      = 5;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 8;
  localparam int MAX_DIGITS_DEF = 10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Commands from the sequencer to the converter.
  typedef struct packed {
    logic load;    // take a new magnitude, clear the digit register
    logic dshift;  // drop the top digit, move the rest up
  } ctrl_t;

  // Status from the converter to the sequencer.
  typedef struct packed {
    logic               done;  // last magnitude bit goes in this cycle
    logic               ovf;   // digits were lost off the top
    logic [DIGIT_W-1:0] top;   // most significant digit held
  } stat_t;

endpackage

// ===== hw/rtl/sida_in_if.sv =====
interface sida_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== hw/rtl/sida_out_if.sv =====
interface sida_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink (input valid, input ascii_char, input last, output ready);
endinterface

// ===== hw/rtl/sida_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add three).
module sida_dabble #(
  parameter int MAX_DIGITS = sida_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sida_pkg::ctrl_t              ctrl_i,
  input  logic [sida_pkg::VALUE_W-1:0] mag_i,
  output sida_pkg::stat_t              stat_o
);
  import sida_pkg::*;

  localparam int BCD_W = MAX_DIGITS * DIGIT_W;

  logic [VALUE_W-1:0]   mag_q;
  logic [BCD_W-1:0]     bcd_q;
  logic [BCD_W-1:0]     corr;
  logic [BIT_CNT_W-1:0] bit_cnt_q;
  logic                 run_q;
  logic                 ovf_q;
  logic                 last_bit;

  // Correct every digit of five or more before the doubling shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      corr[i*DIGIT_W +: DIGIT_W] = (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) ?
                                   bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3 :
                                   bcd_q[i*DIGIT_W +: DIGIT_W];
    end
  end

  assign last_bit = (bit_cnt_q == BIT_CNT_W'(VALUE_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      bit_cnt_q <= '0;
    end else if (ctrl_i.load) begin
      run_q     <= 1'b1;
      bit_cnt_q <= '0;
    end else if (run_q) begin
      bit_cnt_q <= bit_cnt_q + 1'b1;
      if (last_bit) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mag_q <= mag_i;
      bcd_q <= '0;
      ovf_q <= 1'b0;
    end else if (run_q) begin
      mag_q <= mag_q << 1;
      bcd_q <= {corr[BCD_W-2:0], mag_q[VALUE_W-1]};
      ovf_q <= ovf_q | corr[BCD_W-1];
    end else if (ctrl_i.dshift) begin
      bcd_q <= bcd_q << DIGIT_W;
    end
  end

  assign stat_o.done = run_q & last_bit;
  assign stat_o.ovf  = ovf_q;
  assign stat_o.top  = bcd_q[BCD_W-1 -: DIGIT_W];

endmodule

// ===== hw/rtl/signed_integer_to_decimal_ascii.sv =====
// Signed 32-bit integer to decimal ASCII text. Each value taken on in_i is
// sent out on out_o as its decimal characters, most significant first: a '-'
// ahead of negative values, then the digits, with last set on the final
// character. Zero gives the single character '0', and the most negative value
// converts exactly. If MAX_DIGITS is smaller than the digit count of a value,
// only its MAX_DIGITS least significant digits are sent (leading zeros of that
// tail included). One value is converted at a time: after the accept cycle the
// bit-serial converter takes one magnitude bit per cycle, then the sequencer
// drops leading zero positions (up to MAX_DIGITS - 1), settles on the top
// digit and sends the characters back to back while out_o is not stalled.
// in_i is ready again as soon as the final character sits in the output
// register, so the next conversion overlaps the wait for it.
`include "signed_integer_to_decimal_ascii_defines.svh"

module signed_integer_to_decimal_ascii #(
  parameter int MAX_DIGITS = sida_pkg::MAX_DIGITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  sida_in_if.sink    in_i,
  sida_out_if.source out_o
);
  import sida_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;  // wait for a value
  localparam logic [2:0] ST_CONV  = 3'd1;  // converter shifts bits in
  localparam logic [2:0] ST_SKIP  = 3'd2;  // drop leading zero digits
  localparam logic [2:0] ST_SIGN  = 3'd3;  // send the minus sign
  localparam logic [2:0] ST_DIGIT = 3'd4;  // send digits, top first

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;    // digits still to send
  logic               neg_q;
  logic [VALUE_W-1:0] raw;
  logic [VALUE_W-1:0] mag;
  logic               in_xfer;
  logic               load_ok;         // output register may take a character
  logic               skip_zero;
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  out_char_q, out_char_d;
  logic               out_last_q, out_last_d;
  ctrl_t              ctrl;
  stat_t              stat;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid & in_i.ready;

  // Unsigned magnitude: the two's complement negation is exact for the most
  // negative value once read as unsigned.
  assign raw = in_i.value;
  assign mag = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

  assign load_ok = !out_valid_q || out_o.ready;

  // A top digit is a leading zero if it is zero, more digits follow, and no
  // digit fell off the top of the converter.
  assign skip_zero = (cnt_q > CNT_W'(1)) && !stat.ovf && (stat.top == '0);

  assign ctrl.load   = in_xfer;
  assign ctrl.dshift = ((state_q == ST_SKIP) && skip_zero) ||
                       ((state_q == ST_DIGIT) && load_ok);

  sida_dabble #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dabble (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .mag_i (mag),
    .stat_o(stat)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    // Retire a character the sink has taken.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (stat.done) begin
          state_d = ST_SKIP;
          cnt_d   = CNT_W'(MAX_DIGITS);
        end
      end
      ST_SKIP: begin
        if (skip_zero) begin
          cnt_d = cnt_q - 1'b1;
        end else begin
          state_d = neg_q ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
          state_d     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_ZERO + CHAR_W'(stat.top);
          out_last_d  = (cnt_q == CNT_W'(1));
          cnt_d       = cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: sign, output character.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      neg_q <= raw[VALUE_W-1];
    end
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.ascii_char = out_char_q;
  assign out_o.last       = out_last_q;

  // An accepted value always starts a conversion.
  `SIDA_ASSERT(a_accept_starts_conv, in_xfer |=> (state_q == ST_CONV))
  // Digits remain whenever the digit state is active.
  `SIDA_ASSERT(a_digit_cnt_nonzero, (state_q == ST_DIGIT) |-> (cnt_q != '0))
  // Sending the final digit flags last and frees the input side.
  `SIDA_ASSERT(a_final_digit_last,
      ((state_q == ST_DIGIT) && load_ok && (cnt_q == CNT_W'(1))) |=>
      (out_o.valid && out_o.last && (state_q == ST_IDLE)))
  // Out_o offers nothing once reset has been sampled by the clock.
  `SIDA_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |=> !out_o.valid)

endmodule
